### src/bba_pkg.sv
// Shared types and constants of the buddy block allocator.
package bba_pkg;

	// Fixed field widths
	localparam int SIZE_W   = 20;
	localparam int STATUS_W = 2;
	localparam int GLOG_W   = 5;
	// Level numbers, wide enough for the largest region
	localparam int LG_W     = 6;

	// Request codes
	localparam logic FN_ALLOC = 1'b0;
	localparam logic FN_FREE  = 1'b1;

	// State of one tree node
	typedef enum logic [1:0] {
		NS_ABSENT  = 2'd0,
		NS_EMPTY   = 2'd1,
		NS_PARTIAL = 2'd2,
		NS_FULL    = 2'd3
	} node_st_t;

	// Result codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_NO_BLOCK  = 2'd1,
		ST_TOO_LARGE = 2'd2,
		ST_BAD_ADDR  = 2'd3
	} status_t;

	// Sequencer phases
	typedef enum logic [3:0] {
		PH_CLEAR,
		PH_IDLE,
		PH_DECODE,
		PH_A_RD,
		PH_A_EV,
		PH_S_RIGHT,
		PH_S_LEFT,
		PH_BACK,
		PH_F_RD,
		PH_F_EV,
		PH_M_RD,
		PH_M_EV,
		PH_M_WR,
		PH_FIN
	} phase_t;

endpackage

### src/bba_node_ram.sv
// Node state memory: one write port, one read port with registered data.
module bba_node_ram #(
	parameter int AW = 15
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  bba_pkg::node_st_t   wdata,
	input  logic [AW-1:0]       raddr,
	output bba_pkg::node_st_t   rdata
);
	import bba_pkg::*;

	node_st_t mem [2**AW];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, registered output
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### src/bba_walker.sv
// Tree walk sequencer: clearing pass, allocate search with split, free with merge.
module bba_walker #(
	parameter int REGION_LOG2    = 19,
	parameter int MIN_BLOCK_LOG2 = 5
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic                                   func,
	input  logic [bba_pkg::SIZE_W-1:0]             request_size,
	input  logic [REGION_LOG2-1:0]                 block_address,
	output logic                                   idle,
	input  logic                                   slot_free,
	output logic                                   done,
	output bba_pkg::status_t                       res_status,
	output logic [REGION_LOG2-1:0]                 res_addr,
	output logic [bba_pkg::GLOG_W-1:0]             res_log2,
	output logic                                   mem_we,
	output logic [REGION_LOG2-MIN_BLOCK_LOG2:0]    mem_waddr,
	output bba_pkg::node_st_t                      mem_wdata,
	output logic [REGION_LOG2-MIN_BLOCK_LOG2:0]    mem_raddr,
	input  bba_pkg::node_st_t                      mem_rdata
);
	import bba_pkg::*;

	localparam int IW = REGION_LOG2 - MIN_BLOCK_LOG2 + 1;
	localparam int RW = REGION_LOG2;
	localparam logic [LG_W-1:0] LG_TOP = LG_W'(REGION_LOG2);
	localparam logic [LG_W-1:0] LG_MIN = LG_W'(MIN_BLOCK_LOG2);
	localparam logic [IW-1:0]   ROOT   = IW'(1);

	phase_t          ph_q, ph_d;
	logic [IW-1:0]   idx_q, idx_d;
	logic [IW-1:0]   clr_q, clr_d;
	logic [LG_W-1:0] lg_q, lg_d;
	logic [LG_W-1:0] want_q, want_d;
	logic            func_q, func_d;
	logic [RW-1:0]   addr_q, addr_d;
	status_t         st_q, st_d;
	logic [RW-1:0]   gaddr_q, gaddr_d;
	logic [GLOG_W-1:0] glog_q, glog_d;

	logic [SIZE_W-1:0] size_m1;
	logic [LG_W-1:0]   msb;
	logic [LG_W-1:0]   want_raw;
	logic [LG_W-1:0]   want_clamp;
	logic [IW+RW-1:0]  grant_wide;
	logic [RW-1:0]     grant_addr;
	logic [RW-1:0]     addr_sh;
	logic [RW-1:0]     align_mask;
	logic              aligned;
	logic [IW-1:0]     left_idx;

	// Round the request up to a power of two and clamp to the minimum block
	always_comb begin
		size_m1 = request_size - SIZE_W'(1);
		msb = '0;
		for (int i = 0; i < SIZE_W; i++) begin
			if (size_m1[i]) begin
				msb = LG_W'(i);
			end
		end
		want_raw   = (request_size <= SIZE_W'(2)) ? LG_W'(1) : msb + LG_W'(1);
		want_clamp = (want_raw < LG_MIN) ? LG_MIN : want_raw;
	end

	// Block address from heap index: index shifted by level, top bit drops out
	assign grant_wide = {{RW{1'b0}}, idx_q} << lg_q;
	assign grant_addr = grant_wide[RW-1:0];
	assign left_idx   = {idx_q[IW-2:0], 1'b0};

	// Free path: branch bit and alignment of the address at this level
	assign addr_sh    = addr_q >> (lg_q - LG_W'(1));
	assign align_mask = ~({RW{1'b1}} << lg_q);
	assign aligned    = (addr_q & align_mask) == '0;

	// Next phase, walk position and memory accesses
	always_comb begin
		ph_d      = ph_q;
		idx_d     = idx_q;
		clr_d     = clr_q;
		lg_d      = lg_q;
		want_d    = want_q;
		func_d    = func_q;
		addr_d    = addr_q;
		st_d      = st_q;
		gaddr_d   = gaddr_q;
		glog_d    = glog_q;
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = NS_ABSENT;
		mem_raddr = idx_q;
		done      = 1'b0;
		case (ph_q)
			PH_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = (clr_q == ROOT) ? NS_EMPTY : NS_ABSENT;
				clr_d     = clr_q + IW'(1);
				if (&clr_q) begin
					ph_d = PH_IDLE;
				end
			end
			PH_IDLE: begin
				if (start) begin
					func_d = func;
					addr_d = block_address;
					want_d = want_clamp;
					ph_d   = PH_DECODE;
				end
			end
			PH_DECODE: begin
				idx_d   = ROOT;
				lg_d    = LG_TOP;
				gaddr_d = '0;
				glog_d  = '0;
				if (func_q == FN_FREE) begin
					ph_d = PH_F_RD;
				end else if (want_q > LG_TOP) begin
					st_d = ST_TOO_LARGE;
					ph_d = PH_FIN;
				end else begin
					ph_d = PH_A_RD;
				end
			end
			PH_A_RD: begin
				ph_d = PH_A_EV;
			end
			PH_A_EV: begin
				if (lg_q == want_q) begin
					if (mem_rdata == NS_EMPTY) begin
						mem_we    = 1'b1;
						mem_wdata = NS_FULL;
						st_d      = ST_OK;
						gaddr_d   = grant_addr;
						glog_d    = GLOG_W'(lg_q);
						ph_d      = PH_FIN;
					end else begin
						ph_d = PH_BACK;
					end
				end else if (mem_rdata == NS_PARTIAL) begin
					idx_d = left_idx;
					lg_d  = lg_q - LG_W'(1);
					ph_d  = PH_A_RD;
				end else if (mem_rdata == NS_EMPTY) begin
					mem_we    = 1'b1;
					mem_wdata = NS_PARTIAL;
					ph_d      = PH_S_RIGHT;
				end else begin
					ph_d = PH_BACK;
				end
			end
			PH_S_RIGHT: begin
				mem_we    = 1'b1;
				mem_waddr = left_idx | ROOT;
				mem_wdata = NS_EMPTY;
				idx_d     = left_idx;
				lg_d      = lg_q - LG_W'(1);
				ph_d      = PH_S_LEFT;
			end
			PH_S_LEFT: begin
				mem_we = 1'b1;
				if (lg_q == want_q) begin
					mem_wdata = NS_FULL;
					st_d      = ST_OK;
					gaddr_d   = grant_addr;
					glog_d    = GLOG_W'(lg_q);
					ph_d      = PH_FIN;
				end else begin
					mem_wdata = NS_PARTIAL;
					ph_d      = PH_S_RIGHT;
				end
			end
			PH_BACK: begin
				if (idx_q == ROOT) begin
					st_d = ST_NO_BLOCK;
					ph_d = PH_FIN;
				end else if (idx_q[0]) begin
					idx_d = idx_q >> 1;
					lg_d  = lg_q + LG_W'(1);
				end else begin
					idx_d = idx_q | ROOT;
					ph_d  = PH_A_RD;
				end
			end
			PH_F_RD: begin
				ph_d = PH_F_EV;
			end
			PH_F_EV: begin
				if (mem_rdata == NS_FULL) begin
					if (aligned) begin
						st_d    = ST_OK;
						gaddr_d = addr_q;
						glog_d  = GLOG_W'(lg_q);
						ph_d    = PH_M_RD;
					end else begin
						st_d = ST_BAD_ADDR;
						ph_d = PH_FIN;
					end
				end else if (mem_rdata == NS_PARTIAL && lg_q > LG_MIN) begin
					idx_d = left_idx | IW'(addr_sh[0]);
					lg_d  = lg_q - LG_W'(1);
					ph_d  = PH_F_RD;
				end else begin
					st_d = ST_BAD_ADDR;
					ph_d = PH_FIN;
				end
			end
			PH_M_RD: begin
				mem_raddr = idx_q ^ ROOT;
				if (idx_q == ROOT) begin
					mem_we    = 1'b1;
					mem_wdata = NS_EMPTY;
					ph_d      = PH_FIN;
				end else begin
					ph_d = PH_M_EV;
				end
			end
			PH_M_EV: begin
				mem_we = 1'b1;
				if (mem_rdata == NS_EMPTY) begin
					mem_waddr = idx_q ^ ROOT;
					mem_wdata = NS_ABSENT;
					ph_d      = PH_M_WR;
				end else begin
					mem_wdata = NS_EMPTY;
					ph_d      = PH_FIN;
				end
			end
			PH_M_WR: begin
				mem_we    = 1'b1;
				mem_wdata = NS_ABSENT;
				idx_d     = idx_q >> 1;
				lg_d      = lg_q + LG_W'(1);
				ph_d      = PH_M_RD;
			end
			PH_FIN: begin
				if (slot_free) begin
					done = 1'b1;
					ph_d = PH_IDLE;
				end
			end
			default: begin
				ph_d = PH_IDLE;
			end
		endcase
	end

	// Hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q  <= PH_CLEAR;
			clr_q <= '0;
			idx_q <= ROOT;
			lg_q  <= LG_TOP;
		end else begin
			ph_q  <= ph_d;
			clr_q <= clr_d;
			idx_q <= idx_d;
			lg_q  <= lg_d;
		end
	end

	// Hold request and result payload
	always_ff @(posedge clk) begin
		want_q  <= want_d;
		func_q  <= func_d;
		addr_q  <= addr_d;
		st_q    <= st_d;
		gaddr_q <= gaddr_d;
		glog_q  <= glog_d;
	end

	assign idle       = (ph_q == PH_IDLE);
	assign res_status = st_q;
	assign res_addr   = gaddr_q;
	assign res_log2   = glog_q;

`ifndef ASSERT_OFF
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(ph_q == PH_IDLE || ph_q == PH_FIN) |-> !mem_we)
		else $error("node memory written outside a walk");
	a_idx_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(ph_q != PH_CLEAR) |-> (idx_q != '0))
		else $error("walk index reached zero");
	a_lg_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ph_q == PH_A_EV || ph_q == PH_F_EV || ph_q == PH_S_LEFT)
		|-> (lg_q <= LG_TOP && lg_q >= LG_MIN))
		else $error("walk level out of range");
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (ph_q == PH_IDLE))
		else $error("walker did not return to idle after a result");
`endif

endmodule

### src/buddy_block_allocator_top.sv
// Top level of the buddy block allocator: request handshake, walker, node memory, result register.
// Binary buddy allocator over a 2^REGION_LOG2-byte region with 2^MIN_BLOCK_LOG2-byte
// minimum blocks; node states live in one single-port-read, single-port-write memory
// of 2^(REGION_LOG2-MIN_BLOCK_LOG2+1) entries. After reset a clearing pass writes every
// entry, one per cycle, and in_ready stays low until it ends. One transaction is worked at a
// time, each node visit being a memory read followed by an evaluate step: a free descends the
// tree node by node and then, per merge level, reads the buddy, evaluates it and writes; an
// allocate searches depth-first, writing a right and a left child per split level and
// stepping back on a miss. The next request is taken as soon as the walker is idle, even
// while a result waits in the output register.
module buddy_block_allocator_top #(
	parameter int REGION_LOG2    = 19,
	parameter int MIN_BLOCK_LOG2 = 5
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           func,
	input  logic [bba_pkg::SIZE_W-1:0]     request_size,
	input  logic [REGION_LOG2-1:0]         block_address,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [bba_pkg::STATUS_W-1:0]   status,
	output logic [REGION_LOG2-1:0]         granted_address,
	output logic [bba_pkg::GLOG_W-1:0]     granted_log2
);
	import bba_pkg::*;

	localparam int IW = REGION_LOG2 - MIN_BLOCK_LOG2 + 1;

	logic            idle;
	logic            start;
	logic            slot_free;
	logic            done;
	status_t         res_status;
	logic [REGION_LOG2-1:0] res_addr;
	logic [GLOG_W-1:0] res_log2;
	logic            mem_we;
	logic [IW-1:0]   mem_waddr;
	logic [IW-1:0]   mem_raddr;
	node_st_t        mem_wdata;
	node_st_t        mem_rdata;

	logic            out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [REGION_LOG2-1:0] gaddr_q;
	logic [GLOG_W-1:0] glog_q;

	assign in_ready  = idle;
	assign start     = in_valid & idle;
	assign slot_free = !out_valid_q || out_ready;

	bba_walker #(
		.REGION_LOG2   (REGION_LOG2),
		.MIN_BLOCK_LOG2(MIN_BLOCK_LOG2)
	) u_walker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.func         (func),
		.request_size (request_size),
		.block_address(block_address),
		.idle         (idle),
		.slot_free    (slot_free),
		.done         (done),
		.res_status   (res_status),
		.res_addr     (res_addr),
		.res_log2     (res_log2),
		.mem_we       (mem_we),
		.mem_waddr    (mem_waddr),
		.mem_wdata    (mem_wdata),
		.mem_raddr    (mem_raddr),
		.mem_rdata    (mem_rdata)
	);

	bba_node_ram #(
		.AW(IW)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// Result valid: set on a finished walk, drop when the transaction is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Hold result payload
	always_ff @(posedge clk) begin
		if (done) begin
			status_q <= res_status;
			gaddr_q  <= res_addr;
			glog_q   <= res_log2;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign granted_address = gaddr_q;
	assign granted_log2    = glog_q;

`ifndef ASSERT_OFF
	a_done_slot: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> slot_free)
		else $error("result overwrote a waiting transaction");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> !in_ready)
		else $error("request taken while walker busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(status)))
		else $error("waiting result changed");
`endif

endmodule

### tb/buddy_block_allocator_top_tb.sv
// Self-checking testbench of the buddy block allocator top level.
`timescale 1ns / 100ps

module buddy_block_allocator_top_tb;
	import bba_pkg::*;

	localparam int REGION = 19;
	localparam int MINLG  = 5;
	localparam int NODES  = (1 << (REGION - MINLG + 1)) - 1;

	typedef struct packed {
		status_t            st;
		logic [REGION-1:0]  addr;
		logic [GLOG_W-1:0]  lg;
	} grant_t;

	// Shadow tree of block states and the queue of grants not yet returned
	class grant_board;
		node_st_t tree [1:NODES];
		grant_t   pending [$];
		int       errors;

		function new();
			foreach (tree[i]) tree[i] = NS_ABSENT;
			tree[1] = NS_EMPTY;
			errors = 0;
		endfunction

		// Search depth-first, left first, splitting empty leaves on the way down
		function int find_block(int idx, int lg, int want);
			int got;
			if (idx == 0 || idx > NODES) return 0;
			if (lg == want) begin
				if (tree[idx] == NS_EMPTY) begin
					tree[idx] = NS_FULL;
					return idx;
				end
				return 0;
			end
			if (lg < want || lg <= MINLG || 2 * idx + 1 > NODES) return 0;
			if (tree[idx] == NS_PARTIAL) begin
				got = find_block(2 * idx, lg - 1, want);
				if (got != 0) return got;
				return find_block(2 * idx + 1, lg - 1, want);
			end
			if (tree[idx] == NS_EMPTY) begin
				tree[idx]         = NS_PARTIAL;
				tree[2 * idx]     = NS_EMPTY;
				tree[2 * idx + 1] = NS_EMPTY;
				return find_block(2 * idx, lg - 1, want);
			end
			return 0;
		endfunction

		// Work out the grant for an accepted transaction and queue it
		function grant_t note_request(logic fn, logic [SIZE_W-1:0] size,
			logic [REGION-1:0] addr);
			grant_t r;
			int want, idx, lg, d, buddy;
			bit done;
			r = '{st: ST_OK, addr: '0, lg: '0};
			if (fn == FN_ALLOC) begin
				want = 1;
				while (want < 40 && (64'd1 << want) < size) want++;
				if (want < MINLG) want = MINLG;
				if (want > REGION) begin
					r.st = ST_TOO_LARGE;
				end else begin
					idx = find_block(1, REGION, want);
					if (idx == 0) begin
						r.st = ST_NO_BLOCK;
					end else begin
						d = $clog2(idx + 1) - 1;
						r.addr = REGION'((idx - (1 << d)) << want);
						r.lg   = GLOG_W'(want);
					end
				end
			end else begin
				idx  = 1;
				lg   = REGION;
				done = 0;
				r.st = ST_BAD_ADDR;
				while (!done) begin
					if (tree[idx] == NS_FULL) begin
						if ((addr & ((64'd1 << lg) - 1)) == 0) begin
							tree[idx] = NS_EMPTY;
							// merge empty buddies upward
							while (idx > 1) begin
								buddy = idx ^ 1;
								if (tree[buddy] != NS_EMPTY) break;
								tree[idx]      = NS_ABSENT;
								tree[buddy]    = NS_ABSENT;
								tree[idx >> 1] = NS_EMPTY;
								idx = idx >> 1;
							end
							r = '{st: ST_OK, addr: addr, lg: GLOG_W'(lg)};
						end
						done = 1;
					end else if (tree[idx] == NS_PARTIAL && lg > MINLG &&
						2 * idx + 1 <= NODES) begin
						idx = 2 * idx + addr[lg-1];
						lg--;
					end else begin
						done = 1;
					end
				end
			end
			pending.push_back(r);
			return r;
		endfunction

		// Compare one returned grant with the oldest one waiting
		function void check_result(grant_t got);
			grant_t exp;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result status %0d addr %0h lg %0d",
					$time, got.st, got.addr, got.lg);
				errors++;
				return;
			end
			exp = pending.pop_front();
			if (got.st !== exp.st) begin
				$display("%0t: status expected %0d actual %0d", $time, exp.st, got.st);
				errors++;
			end
			if (got.addr !== exp.addr) begin
				$display("%0t: granted_address expected %0h actual %0h",
					$time, exp.addr, got.addr);
				errors++;
			end
			if (got.lg !== exp.lg) begin
				$display("%0t: granted_log2 expected %0d actual %0d",
					$time, exp.lg, got.lg);
				errors++;
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic              func;
	logic [SIZE_W-1:0] request_size;
	logic [REGION-1:0] block_address;
	logic              out_valid;
	logic              out_ready;
	logic [STATUS_W-1:0] status;
	logic [REGION-1:0] granted_address;
	logic [GLOG_W-1:0] granted_log2;

	grant_board        board;
	logic [REGION-1:0] live_blocks [$];
	int                burst_left;

	buddy_block_allocator_top #(.REGION_LOG2(REGION), .MIN_BLOCK_LOG2(MINLG)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .request_size(request_size), .block_address(block_address),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .granted_address(granted_address), .granted_log2(granted_log2)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hold valid until the transaction is taken, then perhaps idle for a while
	task automatic send_request(logic fn, logic [SIZE_W-1:0] size, logic [REGION-1:0] addr);
		grant_t r;
		int     i;
		in_valid      <= 1'b1;
		func          <= fn;
		request_size  <= size;
		block_address <= addr;
		do @(posedge clk); while (!in_ready);
		r = board.note_request(fn, size, addr);
		if (r.st == ST_OK) begin
			if (fn == FN_ALLOC) begin
				live_blocks.push_back(r.addr);
			end else begin
				for (i = 0; i < live_blocks.size(); i++)
					if (live_blocks[i] == r.addr) begin
						live_blocks.delete(i);
						break;
					end
			end
		end
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 20);
			if ($urandom_range(0, 2) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	endtask

	task automatic alloc(logic [SIZE_W-1:0] size);
		send_request(FN_ALLOC, size, REGION'($urandom));
	endtask

	task automatic release_block(logic [REGION-1:0] addr);
		send_request(FN_FREE, SIZE_W'($urandom), addr);
	endtask

	// Receiver stalls: the ready mode is picked anew at random at intervals
	initial begin
		int mode;
		int cnt;
		out_ready = 1'b0;
		mode = 0;
		cnt  = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				board.check_result('{st: status_t'(status), addr: granted_address,
					lg: granted_log2});
			cnt++;
			if (cnt % 300 == 0) mode = $urandom_range(0, 3);
			case (mode)
				0: out_ready <= 1'b1;
				1: out_ready <= (cnt % 7) < 3;
				2: out_ready <= $urandom_range(0, 3) != 0;
				default: out_ready <= $urandom_range(0, 4) == 0;
			endcase
		end
	end

	// Stimulus
	initial begin
		int n, k, pick;
		board         = new();
		burst_left    = 0;
		in_valid      = 1'b0;
		func          = FN_ALLOC;
		request_size  = '0;
		block_address = '0;
		arst_n        = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: whole region, size extremes, split order, bad frees
		alloc(20'd524288);
		alloc(20'd32);
		release_block(19'd0);
		alloc(20'd524289);
		alloc(20'hFFFFF);
		alloc(20'd0);
		alloc(20'd64);
		alloc(20'd1);
		alloc(20'd33);
		release_block(19'd16);
		release_block(19'd0);
		release_block(19'd96);
		release_block(19'h7FFFF);
		release_block(19'h40000);
		alloc(20'd262144);
		alloc(20'd262144);
		release_block(19'h40000);
		release_block(19'd64);
		alloc(20'd32);
		alloc(20'd2);
		while (live_blocks.size() > 0) release_block(live_blocks[0]);

		// random: mostly well-formed alloc and free, some noise
		for (n = 0; n < 1730; n++) begin
			if (n == 900) begin
				in_valid <= 1'b0;
				while (board.pending.size() != 0) @(posedge clk);
			end
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				k = $urandom_range(0, 19);
				if (k < 2) alloc(SIZE_W'($urandom_range(0, 32)));
				else if (k < 4) alloc(SIZE_W'($urandom_range(65536, 524288)));
				else alloc(SIZE_W'($urandom_range(33, 8192)));
			end else if (pick < 85 && live_blocks.size() > 0) begin
				release_block(live_blocks[$urandom_range(0, live_blocks.size() - 1)]);
			end else if (pick < 92) begin
				release_block(REGION'($urandom));
			end else if (pick < 96) begin
				alloc(SIZE_W'($urandom_range(524289, 1048575)));
			end else begin
				alloc(SIZE_W'($urandom));
			end
		end

		in_valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (board.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Limit on the whole run
	initial begin
		#300ms;
		$display("tb: failure");
		$finish;
	end

endmodule
